@@ design/biq_pkg.sv @@
// Shared types, register indexes and multiplier step codes for the biquad filter.
package biq_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [CFG_ADDR_W-1:0] REG_FF_COEFF_1 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FF_COEFF_2 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FB_COEFF_1 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FB_COEFF_2 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_GAIN = 3'd4;

  localparam logic signed [17:0] FF_COEFF_2_RST = -18'sd65536;

  typedef struct packed {
    logic signed [15:0] sample_in;
    logic               clear_history;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               clipped;
  } out_t;

  // One code per pass through the shared multiplier.
  typedef enum logic [2:0] {
    SEL_B1X1  = 3'd0,
    SEL_B2X2  = 3'd1,
    SEL_A1Y1L = 3'd2,
    SEL_A1Y1H = 3'd3,
    SEL_A2Y2L = 3'd4,
    SEL_A2Y2H = 3'd5,
    SEL_GYL   = 3'd6,
    SEL_GYH   = 3'd7
  } mul_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SAT,
    ST_GAIN,
    ST_GDRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sat;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

@@ design/biq_ctrl.sv @@
// Sequencing state machine for the biquad filter: steps the shared multiplier.
module biq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  biq_pkg::status_t status,
  output biq_pkg::cmd_t    cmd
);

  biq_pkg::state_t state_r, state_nxt;
  logic [2:0]      cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= biq_pkg::ST_IDLE;
      cnt_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.mul_en  = 1'b0;
    cmd.mul_sel = biq_pkg::mul_sel_t'(cnt_r);
    cmd.sat     = 1'b0;
    cmd.finish  = 1'b0;
    case (state_r)
      biq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = 3'd0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = biq_pkg::ST_MAC;
        end
      end
      biq_pkg::ST_MAC: begin
        cmd.mul_en = 1'b1;
        cnt_nxt    = cnt_r + 3'd1;
        if (biq_pkg::mul_sel_t'(cnt_r) == biq_pkg::SEL_A2Y2H) begin
          state_nxt = biq_pkg::ST_DRAIN;
        end
      end
      // The last filter product is added to the accumulator here.
      biq_pkg::ST_DRAIN: begin
        state_nxt = biq_pkg::ST_SAT;
      end
      biq_pkg::ST_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = biq_pkg::ST_GAIN;
      end
      biq_pkg::ST_GAIN: begin
        cmd.mul_en = 1'b1;
        cnt_nxt    = cnt_r + 3'd1;
        if (biq_pkg::mul_sel_t'(cnt_r) == biq_pkg::SEL_GYH) begin
          state_nxt = biq_pkg::ST_GDRAIN;
        end
      end
      biq_pkg::ST_GDRAIN: begin
        state_nxt = biq_pkg::ST_DONE;
      end
      biq_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = biq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = biq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/biq_dp.sv @@
// Datapath for the biquad filter: registers, history, shared multiplier, accumulators.
module biq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [biq_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [biq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  biq_pkg::in_t                        in_data,
  input  biq_pkg::cmd_t                       cmd,
  output biq_pkg::status_t                    status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output biq_pkg::out_t                       out_data
);

  logic signed [17:0] ff1_r, ff2_r, fb1_r, fb2_r;
  logic [16:0]        gain_r;

  logic signed [15:0] x_r, x1_r, x2_r;
  logic signed [39:0] y_r, y1_r, y2_r;

  logic signed [59:0] acc_r;
  logic signed [57:0] gacc_r;
  logic signed [38:0] prod_r;
  logic               prod_vld_r;
  biq_pkg::mul_sel_t  psel_r;
  logic               clip_r;
  logic               out_valid_r;
  biq_pkg::out_t      out_data_r;

  logic signed [17:0] a_op;
  logic signed [20:0] b_op;
  logic signed [38:0] prod_nxt;
  logic signed [59:0] prod_ext, acc_term;
  logic signed [57:0] gprod_ext, gacc_term;
  logic signed [43:0] ysh;
  logic               y_ovf;
  logic signed [39:0] y_sat;
  logic signed [25:0] res_wide;
  logic               res_ovf;
  logic signed [15:0] res_sat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff1_r  <= 18'sd0;
      ff2_r  <= biq_pkg::FF_COEFF_2_RST;
      fb1_r  <= 18'sd0;
      fb2_r  <= 18'sd0;
      gain_r <= 17'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        biq_pkg::REG_FF_COEFF_1:  ff1_r  <= $signed(cfg_wdata);
        biq_pkg::REG_FF_COEFF_2:  ff2_r  <= $signed(cfg_wdata);
        biq_pkg::REG_FB_COEFF_1:  fb1_r  <= $signed(cfg_wdata);
        biq_pkg::REG_FB_COEFF_2:  fb2_r  <= $signed(cfg_wdata);
        biq_pkg::REG_OUTPUT_GAIN: gain_r <= cfg_wdata[16:0];
        default: begin
        end
      endcase
    end
  end

  // Operand selection. The 40-bit history values go through the multiplier in
  // two halves: the low 20 bits unsigned, the high 20 bits signed.
  always_comb begin
    case (cmd.mul_sel)
      biq_pkg::SEL_B1X1: begin
        a_op = ff1_r;
        b_op = {{5{x1_r[15]}}, x1_r};
      end
      biq_pkg::SEL_B2X2: begin
        a_op = ff2_r;
        b_op = {{5{x2_r[15]}}, x2_r};
      end
      biq_pkg::SEL_A1Y1L: begin
        a_op = fb1_r;
        b_op = {1'b0, y1_r[19:0]};
      end
      biq_pkg::SEL_A1Y1H: begin
        a_op = fb1_r;
        b_op = {y1_r[39], y1_r[39:20]};
      end
      biq_pkg::SEL_A2Y2L: begin
        a_op = fb2_r;
        b_op = {1'b0, y2_r[19:0]};
      end
      biq_pkg::SEL_A2Y2H: begin
        a_op = fb2_r;
        b_op = {y2_r[39], y2_r[39:20]};
      end
      biq_pkg::SEL_GYL: begin
        a_op = {1'b0, gain_r};
        b_op = {1'b0, y_r[19:0]};
      end
      biq_pkg::SEL_GYH: begin
        a_op = {1'b0, gain_r};
        b_op = {y_r[39], y_r[39:20]};
      end
      default: begin
        a_op = 18'sd0;
        b_op = 21'sd0;
      end
    endcase
    prod_nxt = a_op * b_op;
  end

  // Weight each registered product by its place in the sum.
  always_comb begin
    prod_ext  = {{21{prod_r[38]}}, prod_r};
    gprod_ext = {{19{prod_r[38]}}, prod_r};
    acc_term  = 60'sd0;
    gacc_term = 58'sd0;
    case (psel_r)
      biq_pkg::SEL_B1X1,
      biq_pkg::SEL_B2X2:  acc_term  = prod_ext <<< 16;
      biq_pkg::SEL_A1Y1L,
      biq_pkg::SEL_A2Y2L: acc_term  = -prod_ext;
      biq_pkg::SEL_A1Y1H,
      biq_pkg::SEL_A2Y2H: acc_term  = -(prod_ext <<< 20);
      biq_pkg::SEL_GYL:   gacc_term = gprod_ext;
      biq_pkg::SEL_GYH:   gacc_term = gprod_ext <<< 20;
      default: begin
      end
    endcase
  end

  // Floor to 16 fraction bits is an arithmetic shift; then clamp to 40 bits.
  always_comb begin
    ysh   = acc_r[59:16];
    y_ovf = (ysh[43:39] != {5{ysh[43]}});
    if (y_ovf) begin
      y_sat = ysh[43] ? {1'b1, {39{1'b0}}} : {1'b0, {39{1'b1}}};
    end else begin
      y_sat = ysh[39:0];
    end
  end

  // Output truncates toward zero: a negative value with a non-zero fraction
  // moves up by one after the floor shift.
  always_comb begin
    res_wide = gacc_r[57:32] + {25'd0, (gacc_r[57] & (|gacc_r[31:0]))};
    res_ovf  = (res_wide[25:15] != {11{res_wide[25]}});
    if (res_ovf) begin
      res_sat = res_wide[25] ? 16'sh8000 : 16'sh7fff;
    end else begin
      res_sat = res_wide[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r        <= 16'sd0;
      x2_r        <= 16'sd0;
      y1_r        <= 40'sd0;
      y2_r        <= 40'sd0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_en;
      if (cmd.load && in_data.clear_history) begin
        x1_r <= 16'sd0;
        x2_r <= 16'sd0;
        y1_r <= 40'sd0;
        y2_r <= 40'sd0;
      end else if (cmd.finish) begin
        x1_r <= x_r;
        x2_r <= x1_r;
        y1_r <= y_r;
        y2_r <= y1_r;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
      psel_r <= cmd.mul_sel;
    end
    if (cmd.load) begin
      x_r    <= in_data.sample_in;
      acc_r  <= {{12{in_data.sample_in[15]}}, in_data.sample_in, 32'd0};
      gacc_r <= 58'sd0;
      clip_r <= 1'b0;
    end else begin
      if (prod_vld_r) begin
        acc_r  <= acc_r + acc_term;
        gacc_r <= gacc_r + gacc_term;
      end
      if (cmd.sat) begin
        y_r    <= y_sat;
        clip_r <= y_ovf;
      end
    end
    if (cmd.finish) begin
      out_data_r.sample_out <= res_sat;
      out_data_r.clipped    <= clip_r | res_ovf;
    end
  end

  assign status.out_busy = out_valid_r & ~out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

@@ design/biquad_iir_filter.sv @@
// Top level of the direct form I biquad filter on 16-bit signed samples.
//
// Samples enter on in_valid/in_ready with in_data (sample_in, clear_history);
// results leave on out_valid/out_ready with out_data (sample_out, clipped).
// One result is produced for every sample, in order.
// A single 18x21-bit multiplier is shared by all products: two feedforward
// taps, two feedback taps split into low and high halves, and the output gain
// split the same way, eight passes in all. The passes for one sample run
// one after another, and a new sample is accepted only once they are done.
// in_ready is high only while the sequencer is idle.
// The result sits in an output register: the next sample is accepted and
// processed while it waits, and the sequencer only holds once a second result
// is ready and the first has still not been taken.
// Configuration writes on cfg_we/cfg_addr/cfg_wdata take effect at once. The
// user must make them while no sample is in flight; the block does not enforce
// this. Reset restores register defaults and zeroes sample and feedback history.
module biquad_iir_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [biq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [biq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  biq_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output biq_pkg::out_t                  out_data
);

  biq_pkg::cmd_t    cmd;
  biq_pkg::status_t status;

  biq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  biq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ test/tb_biquad_iir_filter.sv @@
// Self-checking testbench for the direct form I biquad filter, with its own filter predictor.
module tb_biquad_iir_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time HALF_PERIOD = 4ns;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASES = 10;
  localparam int unsigned ITEMS_PER_PHASE = 105;
  localparam int unsigned TAIL_CYCLES = 20;

  // Addresses past the last register, whose writes must be ignored.
  localparam logic [biq_pkg::CFG_ADDR_W-1:0] REG_SPARE_LO = biq_pkg::REG_OUTPUT_GAIN + 1'b1;
  localparam logic [biq_pkg::CFG_ADDR_W-1:0] REG_SPARE_HI = '1;

  localparam logic [biq_pkg::CFG_DATA_W-1:0] COEFF_MIN = 18'h20000;
  localparam logic [biq_pkg::CFG_DATA_W-1:0] COEFF_MAX = 18'h1FFFF;
  localparam logic [biq_pkg::CFG_DATA_W-1:0] GAIN_UNITY = 18'd65536;
  localparam logic [biq_pkg::CFG_DATA_W-1:0] GAIN_TOP = 18'd131071;

  localparam longint HIST_MAX = 64'sd549755813887;
  localparam longint HIST_MIN = -64'sd549755813888;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_CHECKED} row_kind_t;

  typedef struct {
    row_kind_t                          kind;
    logic [biq_pkg::CFG_ADDR_W-1:0]     addr;
    logic [biq_pkg::CFG_DATA_W-1:0]     wdata;
    logic signed [15:0]                 sample;
    logic                               clear;
    logic signed [15:0]                 want;
    logic                               want_clip;
  } row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [biq_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [biq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  biq_pkg::in_t                   in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  biq_pkg::out_t                  out_data;

  // Predictor state: coefficients, gain and the two histories.
  logic signed [17:0] ff_w1, ff_w2, fb_w1, fb_w2;
  logic [16:0]        gain_q;
  logic signed [15:0] x_hist [2];
  logic signed [39:0] y_hist [2];

  biq_pkg::out_t  expected_out [$];
  row_t           script [$];
  int             mismatches = 0;
  int             cycle_count = 0;
  int             stall_left = 0;
  bit             rx_calm = 1'b0;

  biquad_iir_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic void wipe_history();
    x_hist[0] = '0;
    x_hist[1] = '0;
    y_hist[0] = '0;
    y_hist[1] = '0;
  endfunction

  function automatic void reset_filter_model();
    ff_w1 = '0;
    ff_w2 = biq_pkg::FF_COEFF_2_RST;
    fb_w1 = '0;
    fb_w2 = '0;
    gain_q = '0;
    wipe_history();
  endfunction

  function automatic void apply_reg(logic [biq_pkg::CFG_ADDR_W-1:0] addr,
                                    logic [biq_pkg::CFG_DATA_W-1:0] data);
    case (addr)
      biq_pkg::REG_FF_COEFF_1: ff_w1 = data;
      biq_pkg::REG_FF_COEFF_2: ff_w2 = data;
      biq_pkg::REG_FB_COEFF_1: fb_w1 = data;
      biq_pkg::REG_FB_COEFF_2: fb_w2 = data;
      biq_pkg::REG_OUTPUT_GAIN: gain_q = data[16:0];
      default: ;
    endcase
  endfunction

  // One filter step: the sum is kept exact with 32 fraction bits, floored to
  // 16, clamped to 40 bits, then scaled by the gain and truncated toward zero.
  function automatic biq_pkg::out_t filter_sample(biq_pkg::in_t s);
    longint        acc, y, prod, res;
    logic          clip;
    biq_pkg::out_t r;
    if (s.clear_history) wipe_history();
    acc = longint'(s.sample_in) * 64'sd4294967296;
    acc += longint'(ff_w1) * longint'(x_hist[0]) * 64'sd65536;
    acc += longint'(ff_w2) * longint'(x_hist[1]) * 64'sd65536;
    acc -= longint'(fb_w1) * longint'(y_hist[0]);
    acc -= longint'(fb_w2) * longint'(y_hist[1]);
    y = acc >>> 16;
    clip = 1'b0;
    if (y > HIST_MAX) begin
      y = HIST_MAX;
      clip = 1'b1;
    end
    if (y < HIST_MIN) begin
      y = HIST_MIN;
      clip = 1'b1;
    end
    x_hist[1] = x_hist[0];
    y_hist[1] = y_hist[0];
    x_hist[0] = s.sample_in;
    y_hist[0] = y[39:0];
    prod = y * longint'(gain_q);
    res = prod / 64'sd4294967296;
    if (res > 32767) begin
      res = 32767;
      clip = 1'b1;
    end
    if (res < -32768) begin
      res = -32768;
      clip = 1'b1;
    end
    r.sample_out = res[15:0];
    r.clipped = clip;
    return r;
  endfunction

  function automatic int pick_gap(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 14);
    return $urandom_range(15, 60);
  endfunction

  function automatic biq_pkg::in_t random_item();
    int            roll;
    biq_pkg::in_t  it;
    roll = $urandom_range(0, 99);
    if (roll < 60) it.sample_in = 16'($urandom);
    else if (roll < 65) it.sample_in = 16'sh7FFF;
    else if (roll < 70) it.sample_in = 16'sh8000;
    else if (roll < 92) it.sample_in = 16'($urandom_range(0, 512) - 256);
    else it.sample_in = '0;
    it.clear_history = ($urandom_range(0, 24) == 0);
    return it;
  endfunction

  function automatic logic [biq_pkg::CFG_DATA_W-1:0] random_ff();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return COEFF_MIN;
    if (roll < 16) return COEFF_MAX;
    return biq_pkg::CFG_DATA_W'($urandom);
  endfunction

  task automatic write_reg(input logic [biq_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [biq_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(addr, data);
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    do @(posedge clk); while (expected_out.size() != 0);
  endtask

  task automatic send_item(input biq_pkg::in_t it, input int gap, input bit typed,
                           input biq_pkg::out_t want);
    biq_pkg::out_t predicted;
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predicted = filter_sample(it);
    expected_out.push_back(typed ? want : predicted);
  endtask

  // Result side stalls: mostly short, now and then long, none while calm.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 13) : $urandom_range(14, 60);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    biq_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        $error("unexpected result: sample_out %0d clipped %0b",
               out_data.sample_out, out_data.clipped);
        mismatches++;
      end else begin
        want = expected_out.pop_front();
        if (out_data.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d", want.sample_out, out_data.sample_out);
          mismatches++;
        end
        if (out_data.clipped !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, out_data.clipped);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    bit                             in_cfg;
    bit                             calm;
    biq_pkg::out_t                  want;
    logic [biq_pkg::CFG_DATA_W-1:0] c_ff1, c_ff2, c_fb1, c_fb2, c_gain;
    int                             fb2_mag;

    reset_filter_model();
    // Gain is zero after reset, so the first rows must all come out as zero.
    script = '{
      '{ROW_CHECKED, biq_pkg::REG_FF_COEFF_1, '0, 16'sh7FFF, 1'b0, 16'sd0, 1'b0},
      '{ROW_CHECKED, biq_pkg::REG_FF_COEFF_1, '0, 16'sh8000, 1'b0, 16'sd0, 1'b0},
      '{ROW_CHECKED, biq_pkg::REG_FF_COEFF_1, '0, 16'sd0, 1'b1, 16'sd0, 1'b0},
      '{ROW_CHECKED, biq_pkg::REG_FF_COEFF_1, '0, -16'sd1, 1'b0, 16'sd0, 1'b0},
      '{ROW_CFG, biq_pkg::REG_OUTPUT_GAIN, GAIN_UNITY, '0, 1'b0, '0, 1'b0},
      '{ROW_CHECKED, biq_pkg::REG_FF_COEFF_1, '0, 16'sd12345, 1'b1, 16'sd12345, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, 16'sh8000, 1'b0, '0, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, 16'sh7FFF, 1'b0, '0, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, 16'sh8000, 1'b0, '0, 1'b0},
      // Gain just under two: full-scale inputs saturate the output.
      '{ROW_CFG, biq_pkg::REG_OUTPUT_GAIN, GAIN_TOP, '0, 1'b0, '0, 1'b0},
      '{ROW_CHECKED, biq_pkg::REG_FF_COEFF_1, '0, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1},
      '{ROW_CHECKED, biq_pkg::REG_FF_COEFF_1, '0, 16'sh8000, 1'b1, 16'sh8000, 1'b1},
      '{ROW_CHECKED, biq_pkg::REG_FF_COEFF_1, '0, 16'sd1, 1'b1, 16'sd1, 1'b0},
      // Strong positive feedback drives the internal value into saturation.
      '{ROW_CFG, biq_pkg::REG_FF_COEFF_1, COEFF_MAX, '0, 1'b0, '0, 1'b0},
      '{ROW_CFG, biq_pkg::REG_FF_COEFF_2, COEFF_MIN, '0, 1'b0, '0, 1'b0},
      '{ROW_CFG, biq_pkg::REG_FB_COEFF_1, COEFF_MIN, '0, 1'b0, '0, 1'b0},
      '{ROW_CFG, biq_pkg::REG_FB_COEFF_2, COEFF_MIN, '0, 1'b0, '0, 1'b0},
      '{ROW_CFG, biq_pkg::REG_OUTPUT_GAIN, GAIN_UNITY, '0, 1'b0, '0, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, 16'sh7FFF, 1'b1, '0, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, 16'sh7FFF, 1'b0, '0, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, 16'sh7FFF, 1'b0, '0, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, 16'sh7FFF, 1'b0, '0, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, 16'sh7FFF, 1'b0, '0, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, 16'sh7FFF, 1'b0, '0, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, 16'sh7FFF, 1'b0, '0, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, 16'sh7FFF, 1'b0, '0, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, 16'sh8000, 1'b1, '0, 1'b0},
      // Writes past the last register must leave the filter untouched.
      '{ROW_CFG, REG_SPARE_LO, '1, '0, 1'b0, '0, 1'b0},
      '{ROW_CFG, REG_SPARE_HI, '1, '0, 1'b0, '0, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, 16'sd1000, 1'b0, '0, 1'b0},
      '{ROW_ITEM, biq_pkg::REG_FF_COEFF_1, '0, -16'sd1000, 1'b0, '0, 1'b0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    in_cfg = 1'b0;
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        if (!in_cfg) drain_results();
        write_reg(script[i].addr, script[i].wdata);
        in_cfg = 1'b1;
      end else begin
        in_cfg = 1'b0;
        want.sample_out = script[i].want;
        want.clipped = script[i].want_clip;
        send_item(biq_pkg::in_t'{sample_in: script[i].sample,
                                 clear_history: script[i].clear},
                  pick_gap(1'b0), script[i].kind == ROW_CHECKED, want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      if (phase == 0) begin
        c_ff1 = COEFF_MIN;
        c_ff2 = COEFF_MIN;
        c_fb1 = COEFF_MIN;
        c_fb2 = COEFF_MIN;
        c_gain = '0;
      end else if (phase == 1) begin
        c_ff1 = COEFF_MAX;
        c_ff2 = COEFF_MAX;
        c_fb1 = COEFF_MAX;
        c_fb2 = COEFF_MAX;
        c_gain = GAIN_UNITY;
      end else begin
        c_ff1 = random_ff();
        c_ff2 = random_ff();
        if ($urandom_range(0, 99) < 70) begin
          // Keep the poles inside the unit circle so the output stays lively.
          fb2_mag = $urandom_range(0, 60000);
          c_fb2 = biq_pkg::CFG_DATA_W'(fb2_mag);
          c_fb1 = biq_pkg::CFG_DATA_W'($urandom_range(0, 65536 + fb2_mag - 4000));
          if ($urandom_range(0, 1)) c_fb1 = -c_fb1;
        end else begin
          c_fb1 = random_ff();
          c_fb2 = random_ff();
        end
        if (phase == 2) c_gain = GAIN_TOP;
        else if ($urandom_range(0, 99) < 75)
          c_gain = biq_pkg::CFG_DATA_W'($urandom_range(0, 65536));
        else c_gain = biq_pkg::CFG_DATA_W'($urandom_range(65537, 131071));
      end
      write_reg(biq_pkg::REG_FF_COEFF_1, c_ff1);
      write_reg(biq_pkg::REG_FF_COEFF_2, c_ff2);
      write_reg(biq_pkg::REG_FB_COEFF_1, c_fb1);
      write_reg(biq_pkg::REG_FB_COEFF_2, c_fb2);
      write_reg(biq_pkg::REG_OUTPUT_GAIN, c_gain);
      if ($urandom_range(0, 2) == 0)
        write_reg(biq_pkg::CFG_ADDR_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  biq_pkg::CFG_DATA_W'($urandom));

      calm = ($urandom_range(0, 3) == 0);
      rx_calm = calm;
      repeat (ITEMS_PER_PHASE) begin
        send_item(random_item(), pick_gap(calm), 1'b0, '0);
        if ($urandom_range(0, 79) == 0) drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/biq_pkg.sv
design/biq_ctrl.sv
design/biq_dp.sv
design/biquad_iir_filter.sv
test/tb_biquad_iir_filter.sv
